// ----- design/mtq_pkg.sv -----
// Package for the max-tracking queue: depth, widths, command and status
// codes, and the beat, entry and cell control structs.
// No dependencies.
`timescale 1ns / 1ps

package mtq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic signed [31:0] front_maximum;
        logic [4:0]         count;
        logic               is_empty;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] maximum;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
        logic valid;
        logic tail;
    } t_cell_ctl;

endpackage

// ----- design/mtq_cell.sv -----
// One queue cell: holds a value and the running maximum behind it.
// Depends on mtq_pkg.
`timescale 1ns / 1ps

module mtq_cell
    import mtq_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_value,
    input  t_entry             i_next,
    output t_entry             o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.pop) begin
            // advance towards the front
            n_entry = i_next;
        end else if (i_ctl.push) begin
            if (i_ctl.tail) begin
                n_entry.value   = i_value;
                n_entry.maximum = i_value;
            end else if (i_ctl.valid && (r_entry.maximum < i_value)) begin
                n_entry.maximum = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- design/max_tracking_queue_top.sv -----
// Top level of the max-tracking queue: count, status and result strobe
// around a row of mtq_cell instances. Depends on mtq_pkg and mtq_cell.
`timescale 1ns / 1ps

// The queue takes one command per cycle (busy stays low) and answers every
// command with one result beat, strobed in the cycle after the command is
// taken, one item per cycle. The front entry lives in cell zero; a pop shifts
// every cell one place forward, and a push writes the cell at the current
// count while every occupied cell compares and raises its maximum in
// parallel. Results cannot be held off, so a beat must be taken in the cycle
// its strobe is high.
module max_tracking_queue_top
    import mtq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_result
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_status          r_status;
    t_status          n_status;
    logic             r_strobe;
    logic             accept;
    logic             push_ok;
    logic             pop_ok;
    t_entry           cell_q [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        push_ok  = 1'b0;
        pop_ok   = 1'b0;
        n_status = ST_OK;
        n_count  = r_count;
        unique case (i_item.command)
            CMD_PUSH: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    push_ok = accept;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    pop_ok  = accept;
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_status <= ST_OK;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
            if (accept) begin
                r_count  <= n_count;
                r_status <= n_status;
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl ctl;
        t_entry    next_entry;

        assign ctl.push  = push_ok;
        assign ctl.pop   = pop_ok;
        assign ctl.valid = (CNT_W'(g) < r_count);
        assign ctl.tail  = (CNT_W'(g) == r_count);

        if (g == DEPTH - 1) begin : g_last
            assign next_entry = '0;
        end else begin : g_mid
            assign next_entry = cell_q[g+1];
        end

        mtq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_value (i_item.value),
            .i_next  (next_entry),
            .o_entry (cell_q[g])
        );
    end

    always_comb begin
        o_result.count    = 5'(r_count);
        o_result.is_empty = (r_count == '0);
        o_result.status   = r_status;
        if (r_count == '0) begin
            o_result.front_value   = '0;
            o_result.front_maximum = '0;
        end else begin
            o_result.front_value   = cell_q[0].value;
            o_result.front_maximum = cell_q[0].maximum;
        end
    end

    assign o_strobe = r_strobe;

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for max_tracking_queue_top: a directed table, then random
// push, pop, peek and spare-code beats, each checked against an in-bench queue
// predictor. Depends on mtq_pkg and the design sources under design/.
`timescale 1ns / 1ps

module tb;
    import mtq_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] value;
        logic               typed;
        t_out               view;
    } t_row;

    typedef struct packed {
        logic typed;
        t_out view;
    } t_typed_view;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_item = '0;
    logic o_strobe;
    t_out o_result;

    logic row_typed = 1'b0;
    t_out row_view = '0;
    int   sender_idle_pct = 0;

    logic signed [31:0] slot_value [DEPTH];
    logic signed [31:0] slot_max [DEPTH];
    int head = 0;
    int held = 0;

    t_out        due_views [$];
    t_typed_view due_typed [$];
    int failures = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    max_tracking_queue_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    function automatic t_out track_max_step(logic [1:0] cmd, logic signed [31:0] value);
        t_out r;
        int   k;
        int   s;
        r = '0;
        r.status = ST_OK;
        if (cmd == CMD_PUSH) begin
            if (held >= DEPTH) begin
                r.status = ST_PUSH_FULL;
            end else begin
                for (k = 0; k < held; k++) begin
                    s = (head + k) % DEPTH;
                    if (slot_max[s] < value) slot_max[s] = value;
                end
                s = (head + held) % DEPTH;
                slot_value[s] = value;
                slot_max[s] = value;
                held++;
            end
        end else if (cmd == CMD_POP) begin
            if (held == 0) begin
                r.status = ST_POP_EMPTY;
            end else begin
                head = (head + 1) % DEPTH;
                held--;
            end
        end
        if (held == 0) begin
            r.is_empty = 1'b1;
        end else begin
            r.front_value = slot_value[head];
            r.front_maximum = slot_max[head];
        end
        r.count = 5'(held);
        return r;
    endfunction

    function automatic t_out view_of(logic signed [31:0] fv, logic signed [31:0] fm,
                                     logic [4:0] cnt, logic empty, t_status st);
        t_out r;
        r.front_value = fv;
        r.front_maximum = fm;
        r.count = cnt;
        r.is_empty = empty;
        r.status = st;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5: return $urandom_range(40) - 20;
            default: return $urandom;
        endcase
    endfunction

    task automatic check_view(string src, t_out want, t_out got);
        if (got.front_value !== want.front_value || got.front_maximum !== want.front_maximum
            || got.count !== want.count || got.is_empty !== want.is_empty
            || got.status !== want.status) begin
            failures++;
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display({"%0t %s mismatch: want fv=%0d fm=%0d n=%0d e=%0b st=%0d, ",
                          "got fv=%0d fm=%0d n=%0d e=%0b st=%0d"},
                         $realtime, src, want.front_value, want.front_maximum, want.count,
                         want.is_empty, want.status, got.front_value, got.front_maximum,
                         got.count, got.is_empty, got.status);
        end
    endtask

    always @(posedge i_clk) begin
        t_typed_view tv;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (due_views.size() == 0) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t result beat with nothing due", $realtime);
                end else begin
                    tv = due_typed.pop_front();
                    check_view("predictor", due_views.pop_front(), o_result);
                    if (tv.typed) check_view("table", tv.view, o_result);
                end
            end
            if (start && !busy) begin
                due_views.push_back(track_max_step(i_item.command, i_item.value));
                tv.typed = row_typed;
                tv.view = row_view;
                due_typed.push_back(tv);
            end
            if (o_strobe || (start && !busy)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic send_beat(logic [1:0] cmd, logic signed [31:0] value, logic typed, t_out view);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= '{command: cmd, value: value};
        row_typed <= typed;
        row_view <= view;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        t_row rows [$];
        logic signed [31:0] fill [16];
        int idle_pcts [3];
        int phase_beats [3];
        int p;
        int n;
        int push_pct;
        int r;
        logic [1:0] cmd;

        fill = '{-7, 3, -2, 12, 12, 0, -100, 55, 32'sh5555_5555, 32'shaaaa_aaaa,
                 4, -1, 20, 19, 7, 2};
        idle_pcts = '{9, 85, 0};
        phase_beats = '{170, 170, 160};

        rows.push_back('{CMD_PEEK, 32'sd0, 1'b1, view_of(0, 0, 5'd0, 1'b1, ST_OK)});
        rows.push_back('{CMD_POP, 32'sd0, 1'b1, view_of(0, 0, 5'd0, 1'b1, ST_POP_EMPTY)});
        rows.push_back('{CMD_PUSH, VAL_MIN, 1'b1,
                         view_of(VAL_MIN, VAL_MIN, 5'd1, 1'b0, ST_OK)});
        rows.push_back('{CMD_PUSH, VAL_MAX, 1'b1,
                         view_of(VAL_MIN, VAL_MAX, 5'd2, 1'b0, ST_OK)});
        rows.push_back('{CMD_SPARE, 32'sh5555_5555, 1'b1,
                         view_of(VAL_MIN, VAL_MAX, 5'd2, 1'b0, ST_OK)});
        rows.push_back('{CMD_POP, 32'shffff_ffff, 1'b1,
                         view_of(VAL_MAX, VAL_MAX, 5'd1, 1'b0, ST_OK)});
        rows.push_back('{CMD_POP, 32'sd0, 1'b1, view_of(0, 0, 5'd0, 1'b1, ST_OK)});
        foreach (fill[k]) rows.push_back('{CMD_PUSH, fill[k], 1'b0, '0});
        rows.push_back('{CMD_PUSH, 32'sd999, 1'b0, '0});
        rows.push_back('{CMD_PEEK, 32'sd0, 1'b0, '0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_beat(rows[k].cmd, rows[k].value, rows[k].typed, rows[k].view);

        // hold off until the queue of due results drains
        start <= 1'b0;
        while (due_views.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        push_pct = 50;
        for (p = 0; p < 3; p++) begin
            sender_idle_pct = idle_pcts[p];
            for (n = 0; n < phase_beats[p]; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(2))
                        0: push_pct = 25;
                        1: push_pct = 50;
                        default: push_pct = 75;
                    endcase
                end
                r = $urandom_range(99);
                if (r < push_pct) cmd = CMD_PUSH;
                else if (r < 93) cmd = CMD_POP;
                else if (r < 97) cmd = CMD_PEEK;
                else cmd = CMD_SPARE;
                send_beat(cmd, pick_value(), 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (due_views.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        failures += due_views.size();
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mtq_pkg.sv
design/mtq_cell.sv
design/max_tracking_queue_top.sv
tb/tb.sv
